>>> rtl/eftr_pkg.sv
// Shared types, constants and widths for the edge-function triangle rasterizer.
`default_nettype none
package eftr_pkg;
	localparam int MaxDimDefault = 2048;
	localparam int CoordW = 13;
	localparam int PixW = 11;
	localparam int CfgW = 12;
	localparam int ColorW = 24;
	localparam int EdgeW = 28;
	localparam int SumW = EdgeW + 10;
	localparam int QueueDepth = 4;

	localparam logic [0:0] CfgFrameWidth = 1'b0;
	localparam logic [0:0] CfgFrameHeight = 1'b1;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	// One pixel job handed from the scanner to the shading back end.
	typedef struct packed {
		logic [PixW-1:0] px;
		logic [PixW-1:0] py;
		logic hit;
		logic blend;
		logic fin;
		logic [EdgeW-1:0] a0;
		logic [EdgeW-1:0] a1;
		logic [EdgeW-1:0] a2;
	} pix_job_t;
endpackage
`default_nettype wire

>>> rtl/eftr_front.sv
// Front end: triangle setup, bounding box scan and edge function tests.
`default_nettype none
module eftr_front #(
	parameter int MAX_DIM = eftr_pkg::MaxDimDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic take,
	input wire logic mode,
	input wire logic signed [eftr_pkg::CoordW-1:0] v0x,
	input wire logic signed [eftr_pkg::CoordW-1:0] v0y,
	input wire logic signed [eftr_pkg::CoordW-1:0] v1x,
	input wire logic signed [eftr_pkg::CoordW-1:0] v1y,
	input wire logic signed [eftr_pkg::CoordW-1:0] v2x,
	input wire logic signed [eftr_pkg::CoordW-1:0] v2y,
	input wire logic interp,
	input wire logic [eftr_pkg::CfgW-1:0] fw,
	input wire logic [eftr_pkg::CfgW-1:0] fh,
	output eftr_pkg::pix_job_t job,
	output logic job_valid,
	output logic ld_strobe,
	output logic [eftr_pkg::EdgeW-1:0] area_mag
);
	import eftr_pkg::*;
	localparam logic [CfgW:0] MaxDim = (CfgW+1)'(MAX_DIM);

	logic active_q, blend_q, neg_q;
	logic signed [CoordW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
	logic [PixW-1:0] lx_q, hx_q, ly_q, hy_q, sx_q, sy_q;
	logic [EdgeW-1:0] mag_q;

	// setup math
	logic signed [CoordW+1:0] lxs, hxs, lys, hys, fwc, fhc;
	logic signed [2*CoordW+2:0] area;
	logic empty;
	logic [CfgW:0] fwm, fhm;
	always_comb begin
		fwm = ({1'b0, fw} > MaxDim) ? MaxDim : {1'b0, fw};
		fhm = ({1'b0, fh} > MaxDim) ? MaxDim : {1'b0, fh};
		fwc = $signed({1'b0, fwm}) - 14'sd1;
		fhc = $signed({1'b0, fhm}) - 14'sd1;
		lxs = 14'(v0x); hxs = 14'(v0x); lys = 14'(v0y); hys = 14'(v0y);
		if (14'(v1x) < lxs) lxs = 14'(v1x);
		if (14'(v2x) < lxs) lxs = 14'(v2x);
		if (14'(v1x) > hxs) hxs = 14'(v1x);
		if (14'(v2x) > hxs) hxs = 14'(v2x);
		if (14'(v1y) < lys) lys = 14'(v1y);
		if (14'(v2y) < lys) lys = 14'(v2y);
		if (14'(v1y) > hys) hys = 14'(v1y);
		if (14'(v2y) > hys) hys = 14'(v2y);
		if (lxs < 0) lxs = '0;
		if (lys < 0) lys = '0;
		if (hxs > fwc) hxs = fwc;
		if (hys > fhc) hys = fhc;
		area = 27'(14'(v2x) - 14'(v0x)) * 27'(14'(v1y) - 14'(v0y))
			- 27'(14'(v2y) - 14'(v0y)) * 27'(14'(v1x) - 14'(v0x));
		empty = (area == 0) || (lxs > hxs) || (lys > hys);
	end

	// edge functions for current scan pixel
	logic signed [CoordW+1:0] px, py;
	logic signed [2*CoordW+2:0] w0, w1, w2;
	logic ins, fin;
	always_comb begin
		px = $signed({3'b0, sx_q});
		py = $signed({3'b0, sy_q});
		w0 = 27'(px - 14'(x1_q)) * 27'(14'(y2_q) - 14'(y1_q))
			- 27'(py - 14'(y1_q)) * 27'(14'(x2_q) - 14'(x1_q));
		w1 = 27'(px - 14'(x2_q)) * 27'(14'(y0_q) - 14'(y2_q))
			- 27'(py - 14'(y2_q)) * 27'(14'(x0_q) - 14'(x2_q));
		w2 = 27'(px - 14'(x0_q)) * 27'(14'(y1_q) - 14'(y0_q))
			- 27'(py - 14'(y0_q)) * 27'(14'(x1_q) - 14'(x0_q));
		ins = neg_q ? (w0 <= 0 && w1 <= 0 && w2 <= 0) : (w0 >= 0 && w1 >= 0 && w2 >= 0);
		fin = (sx_q >= hx_q) && (sy_q >= hy_q);
		job.px = sx_q;
		job.py = sy_q;
		job.hit = ins;
		job.blend = blend_q;
		job.fin = fin;
		job.a0 = EdgeW'(w0 < 0 ? -w0 : w0);
		job.a1 = EdgeW'(w1 < 0 ? -w1 : w1);
		job.a2 = EdgeW'(w2 < 0 ? -w2 : w2);
	end

	assign job_valid = take && mode && active_q;
	assign ld_strobe = take && !mode;
	assign area_mag = mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			blend_q <= 1'b0;
			neg_q <= 1'b0;
			mag_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
		end else if (take && !mode) begin
			blend_q <= interp;
			neg_q <= area < 0;
			mag_q <= EdgeW'(area < 0 ? -area : area);
			active_q <= !empty;
			sx_q <= PixW'(lxs);
			sy_q <= PixW'(lys);
		end else if (job_valid) begin
			if (fin) active_q <= 1'b0;
			else if (sx_q >= hx_q) begin
				sx_q <= lx_q;
				sy_q <= sy_q + 1'b1;
			end else sx_q <= sx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !mode) begin
			x0_q <= v0x; y0_q <= v0y; x1_q <= v1x;
			y1_q <= v1y; x2_q <= v2x; y2_q <= v2y;
			lx_q <= PixW'(lxs); hx_q <= PixW'(hxs);
			ly_q <= PixW'(lys); hy_q <= PixW'(hys);
		end
	end
endmodule
`default_nettype wire

>>> rtl/eftr_queue.sv
// Small FIFO of pixel jobs between the scanner and the shader.
`default_nettype none
module eftr_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire eftr_pkg::pix_job_t wdata,
	input wire logic pop,
	output eftr_pkg::pix_job_t rdata,
	output logic nonempty,
	output logic full
);
	import eftr_pkg::*;
	localparam int AW = $clog2(QueueDepth);
	pix_job_t mem_q [QueueDepth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign nonempty = cnt_q != '0;
	assign full = cnt_q == (AW+1)'(QueueDepth);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule
`default_nettype wire

>>> rtl/eftr_shade.sv
// Back end: bit-serial barycentric color divide and result register.
`default_nettype none
module eftr_shade (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_ready,
	input wire eftr_pkg::pix_job_t job,
	input wire logic [eftr_pkg::EdgeW-1:0] area_mag,
	input wire logic [eftr_pkg::ColorW-1:0] c0,
	input wire logic [eftr_pkg::ColorW-1:0] c1,
	input wire logic [eftr_pkg::ColorW-1:0] c2,
	output logic job_pop,
	output logic running,
	output logic done,
	output logic [eftr_pkg::PixW-1:0] px,
	output logic [eftr_pkg::PixW-1:0] py,
	output logic cov,
	output logic [eftr_pkg::ColorW-1:0] color,
	output logic fin
);
	import eftr_pkg::*;
	localparam int CntW = $clog2(SumW + 1);

	div_state_t st_q, st_d;
	pix_job_t job_q;
	logic [1:0] ch_q;
	logic [CntW-1:0] bit_q;
	logic [SumW-1:0] num_q, quo_q;
	logic [EdgeW:0] rem_q;
	logic [ColorW-1:0] col_q;
	logic [SumW-1:0] sum;
	logic [7:0] k0, k1, k2;
	logic use_div, last_bit, last_ch;

	always_comb begin
		case (ch_q)
			2'd0: begin k0 = c0[7:0]; k1 = c1[7:0]; k2 = c2[7:0]; end
			2'd1: begin k0 = c0[15:8]; k1 = c1[15:8]; k2 = c2[15:8]; end
			default: begin k0 = c0[23:16]; k1 = c1[23:16]; k2 = c2[23:16]; end
		endcase
		sum = SumW'(job_q.a0) * SumW'(k0) + SumW'(job_q.a1) * SumW'(k1)
			+ SumW'(job_q.a2) * SumW'(k2);
		use_div = job.hit && job.blend && area_mag != '0;
		last_bit = bit_q == CntW'(SumW - 1);
		last_ch = ch_q == 2'd2;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			DIV_IDLE: if (job_ready) st_d = use_div ? DIV_RUN : DIV_DONE;
			DIV_RUN: if (last_bit && last_ch) st_d = DIV_DONE;
			DIV_DONE: st_d = DIV_IDLE;
			default: st_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		job_pop = st_q == DIV_IDLE && job_ready;
		running = st_q == DIV_RUN;
		done = st_q == DIV_DONE;
	end

	assign px = job_q.px;
	assign py = job_q.py;
	assign cov = job_q.hit;
	assign fin = job_q.fin;
	assign color = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= DIV_IDLE;
		else st_q <= st_d;
	end

	// restoring divide, one quotient bit a cycle, one channel at a time
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			ch_q <= 2'd0;
			bit_q <= '0;
			rem_q <= '0;
			num_q <= '0;
			quo_q <= '0;
			col_q <= !job.hit ? '0 : c0;
		end else if (st_q == DIV_RUN) begin
			logic [SumW-1:0] n;
			logic [EdgeW:0] r, t;
			n = (bit_q == '0) ? sum : num_q;
			t = (bit_q == '0) ? {{EdgeW{1'b0}}, n[SumW-1]} : {rem_q[EdgeW-1:0], n[SumW-1]};
			r = (t >= {1'b0, area_mag}) ? t - {1'b0, area_mag} : t;
			rem_q <= r;
			num_q <= {n[SumW-2:0], 1'b0};
			quo_q <= {quo_q[SumW-2:0], t >= {1'b0, area_mag}};
			if (last_bit) begin
				bit_q <= '0;
				ch_q <= ch_q + 2'd1;
				case (ch_q)
					2'd0: col_q[7:0] <= {quo_q[6:0], t >= {1'b0, area_mag}};
					2'd1: col_q[15:8] <= {quo_q[6:0], t >= {1'b0, area_mag}};
					default: col_q[23:16] <= {quo_q[6:0], t >= {1'b0, area_mag}};
				endcase
			end else bit_q <= bit_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> rtl/edge_function_triangle_raster_top.sv
// Top level of the edge-function triangle rasterizer.
`default_nettype none
// Load with mode 0, then pulse start with mode 1 once per bounding-box pixel.
// A step enters the scanner and joins a four-entry job queue; the shader drains
// it. A flat or uncovered pixel goes from idle straight to done in the shader;
// a blended pixel first passes through the one-bit-per-cycle divider, which
// runs the three color channels in turn. busy is high while the
// queue is full, and for a load also while jobs are queued or a divide is
// running, since those still read the current triangle. Results appear on done
// for one cycle and cannot be stalled.
module edge_function_triangle_raster_top #(
	parameter int MAX_DIM = eftr_pkg::MaxDimDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic mode,
	input wire logic signed [eftr_pkg::CoordW-1:0] vert0_x,
	input wire logic signed [eftr_pkg::CoordW-1:0] vert0_y,
	input wire logic signed [eftr_pkg::CoordW-1:0] vert1_x,
	input wire logic signed [eftr_pkg::CoordW-1:0] vert1_y,
	input wire logic signed [eftr_pkg::CoordW-1:0] vert2_x,
	input wire logic signed [eftr_pkg::CoordW-1:0] vert2_y,
	input wire logic [eftr_pkg::ColorW-1:0] color0,
	input wire logic [eftr_pkg::ColorW-1:0] color1,
	input wire logic [eftr_pkg::ColorW-1:0] color2,
	input wire logic interpolate,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [eftr_pkg::CfgW-1:0] cfg_data,
	output logic done,
	output logic [eftr_pkg::PixW-1:0] pixel_x,
	output logic [eftr_pkg::PixW-1:0] pixel_y,
	output logic covered,
	output logic [eftr_pkg::ColorW-1:0] pixel_color,
	output logic last
);
	import eftr_pkg::*;

	logic [CfgW-1:0] fw_q, fh_q;
	logic [ColorW-1:0] c0_q, c1_q, c2_q;
	logic take, job_valid, ld, pop, ne, full, div_run, load_hold;
	pix_job_t fjob, qjob;
	logic [EdgeW-1:0] amag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= CfgW'(640);
			fh_q <= CfgW'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				CfgFrameWidth: fw_q <= cfg_data;
				CfgFrameHeight: fh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold loads until queued jobs and any running divide using the old triangle are gone
	assign load_hold = ne || div_run;
	assign busy = full || (!mode && load_hold);
	assign take = start && !busy;

	always_ff @(posedge clk) begin
		if (ld) begin
			c0_q <= color0;
			c1_q <= color1;
			c2_q <= color2;
		end
	end

	eftr_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk, .arst_n, .take, .mode,
		.v0x(vert0_x), .v0y(vert0_y), .v1x(vert1_x),
		.v1y(vert1_y), .v2x(vert2_x), .v2y(vert2_y),
		.interp(interpolate), .fw(fw_q), .fh(fh_q),
		.job(fjob), .job_valid, .ld_strobe(ld), .area_mag(amag)
	);

	eftr_queue u_queue (
		.clk, .arst_n, .push(job_valid), .wdata(fjob), .pop,
		.rdata(qjob), .nonempty(ne), .full
	);

	eftr_shade u_shade (
		.clk, .arst_n, .job_ready(ne), .job(qjob), .area_mag(amag),
		.c0(c0_q), .c1(c1_q), .c2(c2_q), .job_pop(pop), .running(div_run), .done,
		.px(pixel_x), .py(pixel_y), .cov(covered), .color(pixel_color),
		.fin(last)
	);

`ifndef SYNTHESIS
	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !take) else $error("item taken with full queue");
	a_uncov_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !covered) |-> pixel_color == '0) else $error("uncovered color");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
`endif
endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the edge-function triangle rasterizer top level.
module tb_top;
	import eftr_pkg::*;

	localparam int Limit = 1_000_000;
	localparam int SettleCycles = 150;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_CFG,
		OP_DRAIN
	} stim_op_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_STEP = 1'b1
	} tri_mode_t;

	typedef struct {
		stim_op_t op;
		tri_mode_t mode;
		logic [5:0][CoordW-1:0] vtx;
		logic [2:0][ColorW-1:0] col;
		logic interp;
		logic [0:0] reg_idx;
		logic [CfgW-1:0] reg_val;
		int idle_pct;
	} stim_t;

	typedef struct {
		logic [PixW-1:0] px;
		logic [PixW-1:0] py;
		logic cov;
		logic [ColorW-1:0] color;
		logic fin;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = 1'b0;
	logic signed [CoordW-1:0] vert0_x = '0, vert0_y = '0, vert1_x = '0;
	logic signed [CoordW-1:0] vert1_y = '0, vert2_x = '0, vert2_y = '0;
	logic [ColorW-1:0] color0 = '0, color1 = '0, color2 = '0;
	logic interpolate = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CfgFrameWidth;
	logic [CfgW-1:0] cfg_data = '0;
	logic done;
	logic [PixW-1:0] pixel_x, pixel_y;
	logic covered;
	logic [ColorW-1:0] pixel_color;
	logic last;

	stim_t stim_q[$];
	pixel_t pixel_q[$];
	logic taken = 1'b0;
	int quiet = 0;
	int cycles = 0;
	int errors = 0;
	int idle_pct = 0;

	// rasterizer shadow state
	longint fw_reg = 640, fh_reg = 480;
	bit tri_active = 0;
	longint vx[6];
	logic [ColorW-1:0] vcol[3];
	bit blend_on = 0, area_neg = 0;
	longint area_mag = 0;
	longint box_lx, box_hx, box_ly, box_hy, scan_px, scan_py;

	edge_function_triangle_raster_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy);
		return (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
	endfunction

	function automatic longint abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Update the shadow state with one accepted transfer; a step of an active triangle queues its pixel.
	task automatic raster_predict();
		longint lx, hx, ly, hy, fw, fh, area, w0, w1, w2, s;
		bit hit, fin;
		logic [ColorW-1:0] c;
		pixel_t p;
		if (mode == MODE_LOAD) begin
			vx[0] = vert0_x; vx[1] = vert0_y; vx[2] = vert1_x;
			vx[3] = vert1_y; vx[4] = vert2_x; vx[5] = vert2_y;
			vcol[0] = color0; vcol[1] = color1; vcol[2] = color2;
			blend_on = interpolate;
			fw = fw_reg > 2048 ? 2048 : fw_reg;
			fh = fh_reg > 2048 ? 2048 : fh_reg;
			lx = vx[0]; hx = vx[0]; ly = vx[1]; hy = vx[1];
			for (int i = 1; i < 3; i++) begin
				if (vx[2*i] < lx) lx = vx[2*i];
				if (vx[2*i] > hx) hx = vx[2*i];
				if (vx[2*i+1] < ly) ly = vx[2*i+1];
				if (vx[2*i+1] > hy) hy = vx[2*i+1];
			end
			if (lx < 0) lx = 0;
			if (ly < 0) ly = 0;
			if (hx > fw - 1) hx = fw - 1;
			if (hy > fh - 1) hy = fh - 1;
			area = edge_fn(vx[0], vx[1], vx[2], vx[3], vx[4], vx[5]);
			area_neg = area < 0;
			area_mag = abs64(area);
			tri_active = !(area == 0 || lx > hx || ly > hy);
			box_lx = lx; box_hx = hx; box_ly = ly; box_hy = hy;
			scan_px = lx; scan_py = ly;
			return;
		end
		if (!tri_active)
			return;
		w0 = edge_fn(vx[2], vx[3], vx[4], vx[5], scan_px, scan_py);
		w1 = edge_fn(vx[4], vx[5], vx[0], vx[1], scan_px, scan_py);
		w2 = edge_fn(vx[0], vx[1], vx[2], vx[3], scan_px, scan_py);
		if (!area_neg)
			hit = w0 >= 0 && w1 >= 0 && w2 >= 0;
		else
			hit = w0 <= 0 && w1 <= 0 && w2 <= 0;
		c = '0;
		if (hit && blend_on && area_mag != 0) begin
			for (int sh = 0; sh < 24; sh += 8) begin
				s = abs64(w0) * longint'(vcol[0][sh+:8]) + abs64(w1) * longint'(vcol[1][sh+:8])
					+ abs64(w2) * longint'(vcol[2][sh+:8]);
				s = s / area_mag;
				c[sh+:8] = s[7:0];
			end
		end else if (hit) begin
			c = vcol[0];
		end
		fin = scan_px >= box_hx && scan_py >= box_hy;
		p.px = scan_px[PixW-1:0];
		p.py = scan_py[PixW-1:0];
		p.cov = hit;
		p.color = c;
		p.fin = fin;
		pixel_q.push_back(p);
		if (fin) begin
			tri_active = 0;
		end else if (scan_px >= box_hx) begin
			scan_px = box_lx;
			scan_py++;
		end else begin
			scan_px++;
		end
	endtask

	// driver: present items at the falling edge, hold until the transfer happens
	always @(negedge clk) begin
		stim_t e;
		logic nstart, nwe;
		nstart = start;
		nwe = 1'b0;
		if (!(start && !taken)) begin
			nstart = 1'b0;
			if (arst_n && stim_q.size() > 0) begin
				e = stim_q[0];
				case (e.op)
					OP_ITEM: begin
						if ($urandom_range(99) >= idle_pct) begin
							mode <= e.mode;
							vert0_x <= e.vtx[0]; vert0_y <= e.vtx[1];
							vert1_x <= e.vtx[2]; vert1_y <= e.vtx[3];
							vert2_x <= e.vtx[4]; vert2_y <= e.vtx[5];
							color0 <= e.col[0]; color1 <= e.col[1]; color2 <= e.col[2];
							interpolate <= e.interp;
							nstart = 1'b1;
							void'(stim_q.pop_front());
						end
					end
					OP_CFG: begin
						cfg_index <= e.reg_idx;
						cfg_data <= e.reg_val;
						nwe = 1'b1;
						void'(stim_q.pop_front());
					end
					default: begin
						// hold off until every pending pixel is back and the block settles
						if (pixel_q.size() == 0 && quiet >= SettleCycles) begin
							idle_pct = e.idle_pct;
							void'(stim_q.pop_front());
						end
					end
				endcase
			end
		end
		start <= nstart;
		cfg_we <= nwe;
	end

	// monitor: predict on each transfer, check each result strobe
	always @(posedge clk) begin
		pixel_t p;
		cycles++;
		quiet++;
		if (cycles > Limit) begin
			$display("simulation failed");
			$finish;
		end else begin
			taken <= start && !busy;
			if (arst_n && start && !busy) begin
				quiet = 0;
				raster_predict();
			end
			if (arst_n && cfg_we) begin
				if (cfg_index == CfgFrameWidth)
					fw_reg = cfg_data;
				else
					fh_reg = cfg_data;
			end
			if (arst_n && done) begin
				quiet = 0;
				if (pixel_q.size() == 0) begin
					errors++;
					$error("unexpected result at x %0d y %0d", pixel_x, pixel_y);
				end else begin
					p = pixel_q.pop_front();
					if (pixel_x !== p.px) begin
						errors++;
						$error("pixel_x expected %0d actual %0d", p.px, pixel_x);
					end
					if (pixel_y !== p.py) begin
						errors++;
						$error("pixel_y expected %0d actual %0d", p.py, pixel_y);
					end
					if (covered !== p.cov) begin
						errors++;
						$error("covered expected %0d actual %0d", p.cov, covered);
					end
					if (pixel_color !== p.color) begin
						errors++;
						$error("pixel_color expected %06h actual %06h", p.color, pixel_color);
					end
					if (last !== p.fin) begin
						errors++;
						$error("last expected %0d actual %0d", p.fin, last);
					end
				end
			end
		end
	end

	task automatic add_load(int x0, int y0, int x1, int y1, int x2, int y2,
			logic [ColorW-1:0] c0, logic [ColorW-1:0] c1, logic [ColorW-1:0] c2, logic ip);
		stim_t e;
		e.op = OP_ITEM;
		e.mode = MODE_LOAD;
		e.vtx[0] = x0; e.vtx[1] = y0; e.vtx[2] = x1;
		e.vtx[3] = y1; e.vtx[4] = x2; e.vtx[5] = y2;
		e.col[0] = c0; e.col[1] = c1; e.col[2] = c2;
		e.interp = ip;
		stim_q.push_back(e);
	endtask

	// Steps carry random junk in the unused fields.
	task automatic add_steps(int n);
		stim_t e;
		for (int i = 0; i < n; i++) begin
			e.op = OP_ITEM;
			e.mode = MODE_STEP;
			for (int k = 0; k < 6; k++)
				e.vtx[k] = $urandom;
			for (int k = 0; k < 3; k++)
				e.col[k] = $urandom;
			e.interp = $urandom_range(1);
			stim_q.push_back(e);
		end
	endtask

	task automatic add_phase(int fw, int fh, int pct);
		stim_t e;
		e.op = OP_DRAIN;
		e.idle_pct = pct;
		stim_q.push_back(e);
		e.op = OP_CFG;
		e.reg_idx = CfgFrameWidth;
		e.reg_val = fw;
		stim_q.push_back(e);
		e.reg_idx = CfgFrameHeight;
		e.reg_val = fh;
		stim_q.push_back(e);
	endtask

	// Mostly small triangles near the visible frame, plus full-range noise.
	task automatic add_random(int fw, int fh, int n_items);
		int cnt, bx, by, span, steps;
		cnt = 0;
		while (cnt < n_items) begin
			if ($urandom_range(99) < 85) begin
				span = $urandom_range(6, 1);
				bx = int'($urandom_range((fw > 2048 ? 2048 : fw) + 8)) - 8;
				by = int'($urandom_range((fh > 2048 ? 2048 : fh) + 8)) - 8;
				add_load(bx + $urandom_range(span), by + $urandom_range(span),
					bx + $urandom_range(span), by + $urandom_range(span),
					bx + $urandom_range(span), by + $urandom_range(span),
					$urandom, $urandom, $urandom, $urandom_range(1));
				steps = $urandom_range((span + 1) * (span + 1) + 2);
			end else begin
				add_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom_range(1));
				steps = $urandom_range(5);
			end
			add_steps(steps);
			cnt += steps + 1;
		end
	endtask

	initial begin
		add_phase(640, 480, 0);
		// directed: step before any load, extremes, degenerate and clipped triangles
		add_steps(2);
		add_load(-4096, -4096, 4095, -4096, -4096, 4095, 24'hFFFFFF, 24'h000000,
			24'hFFFFFF, 1'b1);
		add_steps(3);
		add_load(2, 2, 6, 2, 2, 5, 24'hFF0000, 24'h00FF00, 24'h0000FF, 1'b1);
		add_steps(3);
		add_load(2, 2, 2, 5, 6, 2, 24'hFFFFFF, 24'h123456, 24'h000000, 1'b0);
		add_steps(2);
		add_load(1, 1, 3, 3, 5, 5, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		add_steps(1);
		add_load(-20, -20, -10, -20, -20, -5, 24'h000000, 24'h000000, 24'h000000, 1'b0);
		add_steps(1);
		add_load(636, 476, 4095, 476, 636, 4095, 24'h808080, 24'hFFFFFF, 24'h000000, 1'b1);
		add_steps(2);
		add_phase(640, 480, 0);
		add_random(640, 480, 340);
		add_phase(4095, 1, 45);
		add_random(4095, 1, 340);
		add_phase(2048, 2048, 0);
		add_random(2048, 2048, 340);
		add_phase(23, 17, 20);
		add_random(23, 17, 340);
		add_phase(0, 4095, 45);
		add_random(0, 4095, 60);
		add_phase(1, 1, 20);
		add_random(1, 1, 60);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (stim_q.size() > 0 || pixel_q.size() > 0 || quiet < 200)
			@(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
